[design/k_group_reversal_buffer_core_macros.svh]
// Assertion helpers shared by the block's modules.
// Both expect clk and rst_n in scope.
`ifndef K_GROUP_REVERSAL_BUFFER_CORE_MACROS_SVH
`define K_GROUP_REVERSAL_BUFFER_CORE_MACROS_SVH

// Same-cycle implication
`define KGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kgr_pkg.sv]
package kgr_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;

  // Controller states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_FETCH,
    ST_DRAIN
  } kgr_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;    // take input item, store it
    logic rd_first;  // issue read of first result of the group
    logic load;      // move read data into the output register
  } kgr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic flush;     // incoming item closes a group or the list
    logic tail;      // data waiting in the RAM read port is the last result
    logic out_free;  // output register can take a new item this cycle
  } kgr_sts_t;

endpackage

[design/kgr_ram.sv]
module kgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/kgr_ctrl.sv]
module kgr_ctrl
  import kgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  kgr_sts_t sts,
  output kgr_cmd_t cmd
);

  `include "k_group_reversal_buffer_core_macros.svh"

  kgr_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.flush) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd_first = 1'b1;
        state_nxt    = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.tail) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  // a flush is always followed by the first read
  `KGR_ASSERT_NEXT(a_flush_fetch, cmd.accept && sts.flush, cmd.rd_first, "flush without fetch")
  // loading only into a free output slot
  `KGR_ASSERT_NOW(a_load_free, cmd.load, sts.out_free, "load into busy output")
  // input never taken while a group drains
  `KGR_ASSERT_NOW(a_no_accept_drain, cmd.rd_first || cmd.load, !in_ready, "accept during drain")

endmodule

[design/kgr_dpath.sv]
module kgr_dpath
  import kgr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_run_end,
  output logic               out_list_end,
  input  kgr_cmd_t           cmd,
  output kgr_sts_t           sts
);

  `include "k_group_reversal_buffer_core_macros.svh"

  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [CFG_W-1:0]   gsize_r, gsize_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  logic [CW-1:0]      grp_n_r, grp_n_nxt;
  logic               rev_r, rev_nxt;
  logic               last_r, last_nxt;
  logic [CW-1:0]      seq_r, seq_nxt;
  logic               oval_r, oval_nxt;
  logic [VALUE_W-1:0] odata_r;
  logic               orun_r, olist_r;

  logic [CW-1:0]      eff_k;
  logic [CW-1:0]      n_in;
  logic [CW-1:0]      rd_seq;
  logic [CW-1:0]      rd_full;
  logic               rd_en;
  logic [VALUE_W-1:0] rd_data;

  // effective group size: zero acts as one, clamp to MAX_GROUP
  always_comb begin
    if (gsize_r == '0) begin
      eff_k = CW'(1);
    end else if (32'(gsize_r) > 32'(MAX_GROUP)) begin
      eff_k = CW'(MAX_GROUP);
    end else begin
      eff_k = CW'(gsize_r);
    end
  end

  // count after storing the incoming item
  assign n_in = held_r + CW'(1);

  assign sts.flush    = (n_in >= eff_k) || in_last;
  assign sts.tail     = ((seq_r + CW'(1)) == grp_n_r);
  assign sts.out_free = !oval_r || out_ready;

  // read address: output position, mirrored for a reversed group
  assign rd_seq  = cmd.rd_first ? '0 : (seq_r + CW'(1));
  assign rd_full = rev_r ? (grp_n_r - CW'(1) - rd_seq) : rd_seq;
  assign rd_en   = cmd.rd_first || (cmd.load && !sts.tail);

  kgr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_GROUP)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept),
    .wr_addr (held_r[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_full[AW-1:0]),
    .rd_data (rd_data)
  );

  // control next values
  always_comb begin
    gsize_nxt = gsize_r;
    held_nxt  = held_r;
    grp_n_nxt = grp_n_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    seq_nxt   = seq_r;
    oval_nxt  = oval_r;
    if (cfg_wr) begin
      gsize_nxt = cfg_data;
    end
    if (cmd.accept) begin
      held_nxt = n_in;
      if (sts.flush) begin
        held_nxt  = '0;
        grp_n_nxt = n_in;
        rev_nxt   = (n_in >= eff_k);
        last_nxt  = in_last;
      end
    end
    if (cmd.rd_first) begin
      seq_nxt = '0;
    end else if (cmd.load && !sts.tail) begin
      seq_nxt = seq_r + CW'(1);
    end
    if (cmd.load) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r <= CFG_W'(1);
      held_r  <= '0;
      grp_n_r <= '0;
      rev_r   <= 1'b0;
      last_r  <= 1'b0;
      seq_r   <= '0;
      oval_r  <= 1'b0;
    end else begin
      gsize_r <= gsize_nxt;
      held_r  <= held_nxt;
      grp_n_r <= grp_n_nxt;
      rev_r   <= rev_nxt;
      last_r  <= last_nxt;
      seq_r   <= seq_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      odata_r <= rd_data;
      orun_r  <= sts.tail;
      olist_r <= sts.tail && last_r;
    end
  end

  assign out_valid    = oval_r;
  assign out_value    = odata_r;
  assign out_run_end  = orun_r;
  assign out_list_end = olist_r;

  // a partial group never reaches the store depth
  `KGR_ASSERT_NOW(a_held_bound, 1'b1, 32'(held_r) < 32'(MAX_GROUP), "held count overflow")
  // loads stay inside the current group
  `KGR_ASSERT_NOW(a_seq_bound, cmd.load, seq_r < grp_n_r, "drain past group")
  // the store is empty once the last result of a group is loaded
  `KGR_ASSERT_NEXT(a_empty_after, cmd.load && sts.tail, held_r == '0, "items left after drain")

endmodule

[design/k_group_reversal_buffer_core.sv]
// An item that closes a group or the list moves the controller to ST_FETCH, which
//   reads the first result from the store, and then to ST_DRAIN, which loads
//   results into the output register, one per cycle unless stalled.
// Input is held off from the flush until the last result is loaded, as the one group
//   store is filled and then read in turn.
// Reset: rst_n synchronous, active low; empties the group, sets group_size to 1.
module k_group_reversal_buffer_core
  import kgr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration: group_size
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   cfg_data,
  // input items
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] item_value
  input  logic               in_tlast,   // list_end
  // result items
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [31:0] out_value
  output logic               out_tlast,  // run_end
  output logic [0:0]         out_tuser   // [0] out_list_end
);

  kgr_cmd_t cmd;
  kgr_sts_t sts;
  logic     list_end_q;

  assign cfg_ready = 1'b1;

  kgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kgr_dpath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_valid),
    .cfg_data     (cfg_data),
    .in_value     (in_tdata),
    .in_last      (in_tlast),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_value    (out_tdata),
    .out_run_end  (out_tlast),
    .out_list_end (list_end_q),
    .cmd          (cmd),
    .sts          (sts)
  );

  assign out_tuser = list_end_q;

endmodule
